// File: hw/rtl/sbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants of the subresource barrier tracker.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int RESULT_CAP = 64;
    localparam logic [1:0] CFG_LEVELS = 2'd0;
    localparam logic [1:0] CFG_LAYERS = 2'd1;
    localparam logic [1:0] CFG_WMASK  = 2'd2;
    localparam logic [63:0] WMASK_RESET = 64'h11040;

    typedef struct packed {
        logic [31:0] layout;
        logic [63:0] stage;
        logic [63:0] access;
    } entry_t;

    typedef struct packed {
        logic        barrier_valid;
        logic        whole_image;
        logic        last_barrier;
        logic [63:0] src_stage;
        logic [63:0] src_access;
        logic [31:0] old_layout;
        logic [31:0] dst_layout;
        logic [63:0] dst_access;
        logic [63:0] dst_stage;
        logic [31:0] dst_aspect;
        logic [2:0]  level_index;
        logic [2:0]  layer_index;
    } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/sbt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbt_cell
// One position of the split state; loads its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module sbt_cell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire sbt_pkg::entry_t entry_in,
    output sbt_pkg::entry_t      entry_out
);
    import sbt_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule
`default_nettype wire

// File: hw/rtl/subresource_barrier_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// subresource_barrier_tracker
// Tracks image access state and emits the barriers that transitions need.
// ----------------------------------------------------------------------------
// A request on a whole (unsplit) state goes from idle straight to the flush state.
// A partial request, or any request while the state is split, walks all
// MAX_LEVELS*MAX_LAYERS positions through a ring of cells, one position per
// cycle at the head of the ring while the result side does not stall.
// One request is in flight at a time; s_tready is high only when idle.
module subresource_barrier_tracker #(
    parameter int MAX_LEVELS = 8,
    parameter int MAX_LAYERS = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // new_layout, new_access, new_stage, aspect_mask, first_level,
    // level_span, first_layer, layer_span, zero fill
    input  wire logic [207:0] s_tdata,
    // has_subrange
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // src_stage, src_access, old_layout, dst_layout, dst_access, dst_stage,
    // dst_aspect, level_index, layer_index, zero fill
    output logic [359:0]      m_tdata,
    // barrier_valid, whole_image
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import sbt_pkg::*;

    localparam int POSITIONS = MAX_LEVELS * MAX_LAYERS;
    localparam int CW = 5;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t state_reg;
    logic [3:0] levels_reg, layers_reg;
    logic [63:0] wmask_reg;
    logic split_reg, partial_reg, fill_reg;
    entry_t whole_reg, req_reg;
    logic [31:0] aspect_reg;
    logic [CW-1:0] lo_lv_reg, end_lv_reg, lo_ly_reg, end_ly_reg;
    logic [CW-1:0] lv_reg, ly_reg;
    logic [6:0] cnt_reg;
    logic pend_valid_reg;
    result_t pend_reg, out_reg;
    logic out_valid_reg;

    entry_t cell_out [POSITIONS];
    entry_t head, new_entry;
    logic shift_en, out_free, need, aff, emit, last_pos, accept;
    logic in_sub, in_partial;
    logic [2:0] in_flv, in_fly;
    logic [3:0] in_nlv, in_nly;
    entry_t in_req;
    result_t walk_res, whole_res, none_res, flush_res;

    assign in_req.layout = s_tdata[31:0];
    assign in_req.access = s_tdata[95:32];
    assign in_req.stage  = s_tdata[159:96];
    assign in_flv = s_tdata[194:192];
    assign in_nlv = s_tdata[198:195];
    assign in_fly = s_tdata[201:199];
    assign in_nly = s_tdata[205:202];
    assign in_sub = s_tuser[0];
    assign in_partial = in_sub && (in_flv != 3'd0 || in_fly != 3'd0 ||
                        in_nlv != levels_reg || in_nly != layers_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || m_tready;
    assign shift_en = (state_reg == ST_WALK) && out_free;

    // head of the ring, or the whole state while the split is being filled
    assign head = fill_reg ? whole_reg : cell_out[0];
    assign need = head.layout != req_reg.layout || head.access != req_reg.access ||
                  (head.access & wmask_reg) != 64'd0;
    assign aff = lv_reg >= lo_lv_reg && lv_reg < end_lv_reg &&
                 lv_reg < CW'(levels_reg) && ly_reg >= lo_ly_reg &&
                 ly_reg < end_ly_reg && ly_reg < CW'(layers_reg);
    assign emit = aff && need && cnt_reg < 7'(RESULT_CAP);
    assign new_entry = (aff && need) ? req_reg : head;
    assign last_pos = lv_reg == CW'(MAX_LEVELS - 1) && ly_reg == CW'(MAX_LAYERS - 1);

    genvar gi;
    generate
        for (gi = 0; gi < POSITIONS; gi++) begin : g_ring
            sbt_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .entry_in ((gi == POSITIONS - 1) ? new_entry : cell_out[(gi + 1) % POSITIONS]),
                .entry_out(cell_out[gi])
            );
        end
    endgenerate

    always_comb begin
        walk_res = '0;
        walk_res.barrier_valid = 1'b1;
        walk_res.src_stage = head.stage;
        walk_res.src_access = head.access;
        walk_res.old_layout = head.layout;
        walk_res.dst_layout = req_reg.layout;
        walk_res.dst_access = req_reg.access;
        walk_res.dst_stage = req_reg.stage;
        walk_res.dst_aspect = aspect_reg;
        walk_res.level_index = lv_reg[2:0];
        walk_res.layer_index = ly_reg[2:0];

        whole_res = '0;
        whole_res.barrier_valid = 1'b1;
        whole_res.whole_image = 1'b1;
        whole_res.src_stage = whole_reg.stage;
        whole_res.src_access = whole_reg.access;
        whole_res.old_layout = whole_reg.layout;
        whole_res.dst_layout = in_req.layout;
        whole_res.dst_access = in_req.access;
        whole_res.dst_stage = in_req.stage;
        whole_res.dst_aspect = s_tdata[191:160];

        none_res = '0;
        none_res.last_barrier = 1'b1;

        // final word of the request carries the last flag
        flush_res = pend_valid_reg ? pend_reg : none_res;
        flush_res.last_barrier = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            levels_reg <= 4'd1;
            layers_reg <= 4'd1;
            wmask_reg <= WMASK_RESET;
            split_reg <= 1'b0;
            whole_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LEVELS: levels_reg <= cfg_data[3:0];
                    CFG_LAYERS: layers_reg <= cfg_data[3:0];
                    CFG_WMASK:  wmask_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept) begin
                        req_reg <= in_req;
                        aspect_reg <= s_tdata[191:160];
                        partial_reg <= in_partial;
                        fill_reg <= !split_reg;
                        lv_reg <= '0;
                        ly_reg <= '0;
                        cnt_reg <= '0;
                        lo_lv_reg <= in_partial ? CW'(in_flv) : '0;
                        lo_ly_reg <= in_partial ? CW'(in_fly) : '0;
                        end_lv_reg <= in_partial ? CW'(in_flv) + CW'(in_nlv) : CW'(levels_reg);
                        end_ly_reg <= in_partial ? CW'(in_fly) + CW'(in_nly) : CW'(layers_reg);
                        if (in_partial || split_reg) begin
                            pend_valid_reg <= 1'b0;
                            state_reg <= ST_WALK;
                        end else begin
                            pend_reg <= whole_res;
                            pend_valid_reg <= whole_reg.layout != in_req.layout ||
                                whole_reg.access != in_req.access ||
                                (whole_reg.access & wmask_reg) != 64'd0;
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_WALK: begin
                    if (out_free) begin
                        if (emit && pend_valid_reg) begin
                            out_reg <= pend_reg;
                            out_valid_reg <= 1'b1;
                        end else begin
                            out_valid_reg <= 1'b0;
                        end
                        if (emit) begin
                            pend_reg <= walk_res;
                            pend_valid_reg <= 1'b1;
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                        if (ly_reg == CW'(MAX_LAYERS - 1)) begin
                            ly_reg <= '0;
                            lv_reg <= lv_reg + CW'(1);
                        end else begin
                            ly_reg <= ly_reg + CW'(1);
                        end
                        if (last_pos) begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        out_reg <= flush_res;
                        out_valid_reg <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        whole_reg <= req_reg;
                        if (!pend_valid_reg || partial_reg || split_reg || fill_reg) begin
                            split_reg <= partial_reg;
                        end
                        fill_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_reg.last_barrier;
    assign m_tuser = {out_reg.whole_image, out_reg.barrier_valid};
    assign m_tdata = {2'b00, out_reg.layer_index, out_reg.level_index, out_reg.dst_aspect,
                      out_reg.dst_stage, out_reg.dst_access, out_reg.dst_layout,
                      out_reg.old_layout, out_reg.src_access, out_reg.src_stage};

endmodule
`default_nettype wire

// File: tb/tb_subresource_barrier_tracker.sv
// ----------------------------------------------------------------------------
// tb_subresource_barrier_tracker
// Drives transition requests and configuration writes into the barrier
// tracker, predicts the barrier words from a local copy of the image state and
// compares every result word field by field in order.
// ----------------------------------------------------------------------------
module tb_subresource_barrier_tracker;
    import sbt_pkg::*;

    localparam int NLV = 8;
    localparam int NLY = 8;

    typedef struct packed {
        logic [31:0] layout;
        logic [63:0] access;
        logic [63:0] stage;
        logic [31:0] aspect;
        logic        has_sub;
        logic [2:0]  f_lvl;
        logic [3:0]  n_lvl;
        logic [2:0]  f_lyr;
        logic [3:0]  n_lyr;
    } request_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [207:0]  s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [359:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [63:0]   cfg_data;

    subresource_barrier_tracker uut (.*);

    // predictor state
    logic [3:0]  img_levels;
    logic [3:0]  img_layers;
    logic [63:0] wr_mask;
    logic        is_split;
    entry_t      whole_st;
    entry_t      part_st [NLV*NLY];

    result_t     barrier_q[$];
    int          errors;
    bit          rx_quiet;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("MISMATCH %s at %0t", what, $realtime);
    endtask

    task automatic enqueue_word(input result_t w);
        barrier_q.insert(barrier_q.size(), w);
    endtask

    function automatic bit needs_barrier(entry_t cur, logic [31:0] lay, logic [63:0] acc);
        return cur.layout != lay || cur.access != acc || (cur.access & wr_mask) != 0;
    endfunction

    task automatic predict_barriers(input request_t rq);
        result_t r;
        entry_t  nxt;
        bit      partial;
        int      lv0, lvn, ly0, lyn, cnt;
        partial = rq.has_sub && (rq.f_lvl != 0 || rq.f_lyr != 0 ||
                  rq.n_lvl != img_levels || rq.n_lyr != img_layers);
        nxt.layout = rq.layout;
        nxt.access = rq.access;
        nxt.stage  = rq.stage;
        cnt = 0;
        r = '0;
        r.barrier_valid = 1'b1;
        r.dst_layout = rq.layout;
        r.dst_access = rq.access;
        r.dst_stage  = rq.stage;
        r.dst_aspect = rq.aspect;
        if (partial || is_split) begin
            if (!is_split)
                foreach (part_st[i]) part_st[i] = whole_st;
            lv0 = partial ? rq.f_lvl : 0;
            lvn = partial ? rq.n_lvl : img_levels;
            ly0 = partial ? rq.f_lyr : 0;
            lyn = partial ? rq.n_lyr : img_layers;
            for (int lv = lv0; lv < lv0 + lvn; lv++) begin
                if (lv >= img_levels || lv >= NLV) break;
                for (int ly = ly0; ly < ly0 + lyn; ly++) begin
                    if (ly >= img_layers || ly >= NLY) break;
                    if (needs_barrier(part_st[lv*NLY+ly], rq.layout, rq.access)) begin
                        if (cnt < RESULT_CAP) begin
                            r.src_stage   = part_st[lv*NLY+ly].stage;
                            r.src_access  = part_st[lv*NLY+ly].access;
                            r.old_layout  = part_st[lv*NLY+ly].layout;
                            r.whole_image = 1'b0;
                            r.level_index = lv[2:0];
                            r.layer_index = ly[2:0];
                            enqueue_word(r);
                            cnt++;
                        end
                        part_st[lv*NLY+ly] = nxt;
                    end
                end
            end
            is_split = partial;
        end else if (needs_barrier(whole_st, rq.layout, rq.access)) begin
            r.src_stage   = whole_st.stage;
            r.src_access  = whole_st.access;
            r.old_layout  = whole_st.layout;
            r.whole_image = 1'b1;
            enqueue_word(r);
            cnt = 1;
        end
        whole_st = nxt;
        if (cnt == 0) begin
            r = '0;
            r.last_barrier = 1'b1;
            enqueue_word(r);
        end else begin
            barrier_q[$].last_barrier = 1'b1;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (barrier_q.size() == 0) begin
                report("unexpected word");
            end else begin
                exp_r = barrier_q.pop_front();
                if (m_tuser[0] !== exp_r.barrier_valid) report("barrier_valid");
                if (m_tuser[1] !== exp_r.whole_image) report("whole_image");
                if (m_tlast !== exp_r.last_barrier) report("last_barrier");
                if (m_tdata[63:0] !== exp_r.src_stage) report("src_stage");
                if (m_tdata[127:64] !== exp_r.src_access) report("src_access");
                if (m_tdata[159:128] !== exp_r.old_layout) report("old_layout");
                if (m_tdata[191:160] !== exp_r.dst_layout) report("dst_layout");
                if (m_tdata[255:192] !== exp_r.dst_access) report("dst_access");
                if (m_tdata[319:256] !== exp_r.dst_stage) report("dst_stage");
                if (m_tdata[351:320] !== exp_r.dst_aspect) report("dst_aspect");
                if (m_tdata[354:352] !== exp_r.level_index) report("level_index");
                if (m_tdata[357:355] !== exp_r.layer_index) report("layer_index");
            end
        end
    end

    // result-side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= rx_quiet || ($urandom_range(99) >= 11);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEVELS: img_levels = val[3:0];
            CFG_LAYERS: img_layers = val[3:0];
            CFG_WMASK:  wr_mask = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_request(input request_t rq, input bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 11) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rq.n_lyr, rq.f_lyr, rq.n_lvl, rq.f_lvl,
                     rq.aspect, rq.stage, rq.access, rq.layout};
        s_tuser  <= rq.has_sub;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_barriers(rq);
        s_tvalid <= 1'b0;
        // the tracker drops s_tready after taking a word
        @(posedge aclk);
    endtask

    task automatic drain();
        while (barrier_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // small pool of states so that repeats (no barrier) happen often
    function automatic request_t random_request(int sub_pct);
        request_t rq;
        rq.layout  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        rq.access  = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(3)) << 6;
        rq.stage   = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(3));
        rq.aspect  = $urandom;
        rq.has_sub = $urandom_range(99) < sub_pct;
        rq.f_lvl   = $urandom_range(3) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(1));
        rq.n_lvl   = 4'($urandom_range(8, 1));
        rq.f_lyr   = $urandom_range(3) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(1));
        rq.n_lyr   = 4'($urandom_range(8, 1));
        return rq;
    endfunction

    task automatic test_whole_image();
        request_t rq;
        rq = '0;
        send_request(rq, 0);                       // same as reset: no barrier
        rq.layout = '1; rq.access = '1; rq.stage = '1; rq.aspect = '1;
        send_request(rq, 0);
        send_request(rq, 0);                       // write bits held: barrier again
        rq.has_sub = 1'b1; rq.n_lvl = 4'd1; rq.n_lyr = 4'd1;
        rq.access = 64'h2;
        send_request(rq, 0);                       // full subrange counts as whole
        send_request(rq, 0);
        drain();
    endtask

    task automatic test_split_merge();
        request_t rq;
        write_reg(CFG_LEVELS, 64'd8);
        write_reg(CFG_LAYERS, 64'd8);
        write_reg(CFG_WMASK, 64'd0);
        rq = '0;
        rq.layout = 32'd5; rq.access = 64'h4; rq.stage = 64'h8; rq.aspect = 32'h1;
        rq.has_sub = 1'b1; rq.f_lvl = 3'd7; rq.n_lvl = 4'd8; rq.f_lyr = 3'd7;
        rq.n_lyr = 4'd8;
        send_request(rq, 0);                       // corner only, rest skipped
        rq.f_lvl = 3'd2; rq.n_lvl = 4'd3; rq.f_lyr = 3'd0; rq.n_lyr = 4'd8;
        rq.layout = 32'd6;
        send_request(rq, 0);
        send_request(rq, 0);                       // nothing changes
        rq.has_sub = 1'b0; rq.layout = 32'd9;
        send_request(rq, 0);                       // walk all 64 then merge
        rq.has_sub = 1'b1; rq.f_lvl = 3'd0; rq.n_lvl = 4'd8; rq.n_lyr = 4'd8;
        rq.layout = 32'd10;
        send_request(rq, 0);                       // full range: whole barrier
        drain();
        write_reg(CFG_LEVELS, 64'd0);              // empty image
        write_reg(CFG_LAYERS, 64'd15);
        rq.has_sub = 1'b1; rq.f_lvl = 3'd1; rq.layout = 32'd11;
        send_request(rq, 0);
        rq.has_sub = 1'b0; rq.layout = 32'd12;
        send_request(rq, 0);
        drain();
    endtask

    task automatic test_random(int n);
        request_t rq;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                drain();
                write_reg(CFG_LEVELS, 64'($urandom_range(8, 1)) | (rand64() & ~64'hF));
                write_reg(CFG_LAYERS, 64'($urandom_range(8, 1)));
                write_reg(CFG_WMASK, ($urandom_range(2) == 0) ? rand64() :
                          ($urandom_range(1) ? WMASK_RESET : 64'd0));
            end
            rx_quiet = (i >= 120 && i < 200);
            rq = random_request(40);
            send_request(rq, !rx_quiet);
        end
        rx_quiet = 1'b0;
    endtask

    initial begin
        errors    = 0;
        rx_quiet  = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        img_levels = 4'd1;
        img_layers = 4'd1;
        wr_mask   = WMASK_RESET;
        is_split  = 1'b0;
        whole_st  = '0;
        foreach (part_st[i]) part_st[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_whole_image();
        test_split_merge();
        test_random(480);
        drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
